// ----- rtl/bwsd_pkg.sv -----
// Shared operation codes, status codes and controller/datapath interface types.
package bwsd_pkg;

   // operation codes on req_func
   localparam logic [1:0] FUNC_PUSH     = 2'd0;
   localparam logic [1:0] FUNC_POP_HEAD = 2'd1;
   localparam logic [1:0] FUNC_POP_TAIL = 2'd2;

   // status codes on rsp_status
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic take;     // request beat accepted this cycle
      logic capture;  // load RAM read data into the result word
   } bwsd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pop_hit;  // current request is a pop that will succeed
   } bwsd_stat_type;

endpackage

// ----- rtl/bwsd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bwsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bwsd_ctrl.sv -----
// Controller: sequences accept, RAM read and result delivery.
module bwsd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bwsd_pkg::bwsd_stat_type stat,
   output bwsd_pkg::bwsd_cmd_type  cmd
);
   import bwsd_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      take;

   // a new beat may enter while the held result leaves in the same cycle
   assign req_ready   = (state_ff == S_IDLE) || ((state_ff == S_RESP) && rsp_ready);
   assign rsp_valid   = (state_ff == S_RESP);
   assign take        = req_valid && req_ready;
   assign cmd.take    = take;
   assign cmd.capture = (state_ff == S_READ);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               state_in = stat.pop_hit ? S_READ : S_RESP;
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (take) begin
               state_in = stat.pop_hit ? S_READ : S_RESP;
            end else if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/bwsd_datapath.sv -----
// Datapath: head/tail pointers, fill level, word store and result registers.
module bwsd_datapath #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 req_func,
   input  logic [WORD_WIDTH-1:0]      req_push_word,
   output logic [1:0]                 rsp_status,
   output logic [WORD_WIDTH-1:0]      rsp_popped_word,
   output logic [$clog2(DEPTH+1)-1:0] rsp_fill_level,
   input  bwsd_pkg::bwsd_cmd_type     cmd,
   output bwsd_pkg::bwsd_stat_type    stat
);
   import bwsd_pkg::*;

   localparam int PTR_W  = $clog2(2 * DEPTH);
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(2 * DEPTH - 1);
   localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);
   localparam logic [PTR_W:0]   PTR_MOD   = (PTR_W + 1)'(2 * DEPTH);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

   function automatic logic [IDX_W-1:0] slot_of(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] s;
      s = (p >= PTR_DEPTH) ? (p - PTR_DEPTH) : p;
      return s[IDX_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_LAST : p - PTR_W'(1);
   endfunction

   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [1:0]            status_ff, status_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [WORD_WIDTH-1:0] word_ff;

   logic [PTR_W:0]        diff;
   logic [FILL_W-1:0]     fill;
   logic                  full, empty;
   logic                  is_push, is_pop_head, is_pop_tail;
   logic                  push_ok, pop_head_ok, pop_tail_ok;
   logic [PTR_W-1:0]      head_dec;
   logic                  ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]      ram_wr_addr, ram_rd_addr;
   logic [WORD_WIDTH-1:0] ram_rd_data;

   // fill = (head - tail) mod 2*DEPTH
   assign diff  = {1'b0, head_ff} + ((head_ff < tail_ff) ? PTR_MOD : '0) - {1'b0, tail_ff};
   assign fill  = diff[FILL_W-1:0];
   assign full  = (fill == FILL_MAX);
   assign empty = (fill == '0);

   assign is_push     = (req_func == FUNC_PUSH);
   assign is_pop_head = (req_func == FUNC_POP_HEAD);
   assign is_pop_tail = (req_func == FUNC_POP_TAIL);
   assign push_ok     = is_push && !full;
   assign pop_head_ok = is_pop_head && !empty;
   assign pop_tail_ok = is_pop_tail && !empty;
   assign head_dec    = ptr_dec(head_ff);

   assign stat.pop_hit = pop_head_ok || pop_tail_ok;

   assign ram_wr_en   = cmd.take && push_ok;
   assign ram_wr_addr = slot_of(head_ff);
   assign ram_rd_en   = cmd.take && (pop_head_ok || pop_tail_ok);
   assign ram_rd_addr = is_pop_head ? slot_of(head_dec) : slot_of(tail_ff);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      status_in = STATUS_DONE;
      fill_in   = fill;
      if (push_ok) begin
         head_in = ptr_inc(head_ff);
         fill_in = fill + FILL_W'(1);
      end else if (pop_head_ok) begin
         head_in = head_dec;
         fill_in = fill - FILL_W'(1);
      end else if (pop_tail_ok) begin
         tail_in = ptr_inc(tail_ff);
         fill_in = fill - FILL_W'(1);
      end
      if (is_push && full) begin
         status_in = STATUS_FULL;
      end else if ((is_pop_head || is_pop_tail) && empty) begin
         status_in = STATUS_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else if (cmd.take) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // result registers; a pop word arrives from the RAM in the cycle after the take
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         status_ff <= status_in;
         fill_ff   <= fill_in;
         word_ff   <= '0;
      end else if (cmd.capture) begin
         word_ff   <= ram_rd_data;
      end
   end

   bwsd_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_push_word),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_status      = status_ff;
   assign rsp_popped_word = word_ff;
   assign rsp_fill_level  = fill_ff;

endmodule

// ----- rtl/bounded_work_stealing_deque_unit.sv -----
// Bounded work-stealing deque: top level joining controller and datapath.
//
// A ring deque of DEPTH words of WORD_WIDTH bits. Each request beat carries one
// operation: push at the head, pop from the head, or pop from the tail; each
// yields exactly one response beat with a status (done, full, empty), the
// popped word (zero unless a pop succeeded) and the fill level afterward.
// Refused operations change nothing. A push, a refused pop or an unused code
// answers in the cycle after acceptance; a successful pop first passes through
// a read state, for the registered read of the word store RAM, and answers
// after it. One operation is in flight at a time; a new request is taken in
// the same cycle that the pending response is taken, so pushes can run at
// one per cycle while rsp_ready is held high; a successful pop takes no new
// request during its read state. The word store needs no clearing after reset.
module bounded_work_stealing_deque_unit #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_func,
   input  logic [WORD_WIDTH-1:0]      req_push_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic [WORD_WIDTH-1:0]      rsp_popped_word,
   output logic [$clog2(DEPTH+1)-1:0] rsp_fill_level
);
   import bwsd_pkg::*;

   localparam int FILL_W = $clog2(DEPTH + 1);

   bwsd_cmd_type  cmd;
   bwsd_stat_type stat;

   bwsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bwsd_datapath #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_push_word   (req_push_word),
      .rsp_status      (rsp_status),
      .rsp_popped_word (rsp_popped_word),
      .rsp_fill_level  (rsp_fill_level),
      .cmd             (cmd),
      .stat            (stat)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill_level <= FILL_W'(DEPTH))
      else $error("fill level beyond capacity");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_DONE) |-> rsp_popped_word == '0)
      else $error("refused beat carries a word");

   a_full_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> rsp_fill_level == FILL_W'(DEPTH))
      else $error("full status without full level");

   a_empty_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |-> rsp_fill_level == '0)
      else $error("empty status with nonzero level");

   a_push_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == FUNC_PUSH) |=> rsp_valid)
      else $error("push response late");

endmodule
